[rtl/httpdate_pkg.sv]
// Constants and name tables for the HTTP date parser.
// Used by http_date_parser_top; depends on nothing else.
package httpdate_pkg;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   localparam int unsigned MIN_YEAR = 999;

   localparam logic [23:0] ZONE_GMT = "gmt";

   localparam logic [0:6][23:0] WEEKDAY_NAMES = '{
      "sun", "mon", "tue", "wed", "thu", "fri", "sat"
   };

   localparam logic [0:11][23:0] MONTH_NAMES = '{
      "jan", "feb", "mar", "apr", "may", "jun",
      "jul", "aug", "sep", "oct", "nov", "dec"
   };

   function automatic logic weekday_match(input logic [23:0] name);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < 7; k++) begin
         if (name == WEEKDAY_NAMES[k]) hit = 1'b1;
      end
      return hit;
   endfunction

   // Returns 1 to 12 for a known month name, 0 otherwise.
   function automatic logic [3:0] month_number(input logic [23:0] name);
      logic [3:0] num;
      num = 4'd0;
      for (int k = 0; k < 12; k++) begin
         if (name == MONTH_NAMES[k]) num = 4'(k + 1);
      end
      return num;
   endfunction

endpackage

[rtl/http_date_parser_top.sv]
// HTTP date parser, RFC 1123 form, one byte per transaction.
// The result appears on rsp_valid in the cycle after the final byte is accepted.
// Throughput: one byte per cycle; a final byte waits only while an earlier result
// is still held in the output register and rsp_ready is low.
// Reset (synchronous, active high) clears the parse state and the output valid.
// Depends on httpdate_pkg.
module http_date_parser_top #(
   parameter int NUMBER_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_in,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ok,
   output logic [15:0] rsp_day_out,
   output logic [3:0]  rsp_month_out,
   output logic [15:0] rsp_year_out,
   output logic [15:0] rsp_hour_out,
   output logic [15:0] rsp_minute_out,
   output logic [15:0] rsp_second_out
);

   localparam int NW = NUMBER_WIDTH;

   typedef enum logic [3:0] {
      TOK_WEEKDAY, TOK_DAY, TOK_MONTH, TOK_YEAR, TOK_HOUR,
      TOK_MINUTE, TOK_SECOND, TOK_ZONE, TOK_DONE
   } token_type;

   typedef struct packed {
      token_type      tok;
      logic [1:0]     pos;
      logic [23:0]    name;
      logic [NW-1:0]  acc;
      logic           dig;
      logic [NW-1:0]  day;
      logic [3:0]     month;
      logic [NW-1:0]  year;
      logic [NW-1:0]  hour;
      logic [NW-1:0]  minute;
      logic [NW-1:0]  second;
      logic           err;
      logic           zone;
   } parse_type;

   localparam parse_type PARSE_RESET = '{
      tok: TOK_WEEKDAY, pos: '0, name: '0, acc: '0, dig: 1'b0, day: '0, month: '0,
      year: '0, hour: '0, minute: '0, second: '0, err: 1'b0, zone: 1'b0
   };

   function automatic logic is_number(input token_type t);
      return (t == TOK_DAY) || (t == TOK_YEAR) || (t == TOK_HOUR) ||
             (t == TOK_MINUTE) || (t == TOK_SECOND);
   endfunction

   // Stores the running number in its field and moves to the next token; a year below MIN_YEAR sets err instead.
   function automatic parse_type commit_number(input parse_type s_in);
      parse_type s;
      logic      advance;
      s = s_in;
      advance = 1'b1;
      unique case (s.tok)
         TOK_DAY: begin
            s.day = s.acc;
            s.tok = TOK_MONTH;
         end
         TOK_YEAR: begin
            if (s.acc < NW'(httpdate_pkg::MIN_YEAR)) begin
               s.err = 1'b1;
               advance = 1'b0;
            end else begin
               s.year = s.acc;
               s.tok = TOK_HOUR;
            end
         end
         TOK_HOUR: begin
            s.hour = s.acc;
            s.tok = TOK_MINUTE;
         end
         TOK_MINUTE: begin
            s.minute = s.acc;
            s.tok = TOK_SECOND;
         end
         TOK_SECOND: begin
            s.second = s.acc;
            s.tok = TOK_ZONE;
         end
         default: advance = 1'b0;
      endcase
      if (advance) begin
         s.acc = '0;
         s.dig = 1'b0;
      end
      return s;
   endfunction

   parse_type     state_ff, state_in, parsed;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          res_ok_ff;
   logic [15:0]   res_day_ff, res_year_ff, res_hour_ff, res_minute_ff, res_second_ff;
   logic [3:0]    res_month_ff;

   logic          req_fire;
   logic          digit;
   logic          separator;
   logic [7:0]    lower;
   logic [NW+3:0] times_ten;
   logic [NW-1:0] acc_sat;
   logic [23:0]   shifted_name;
   logic [3:0]    month_hit;
   logic          active;
   logic          handled;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready || !req_end_of_text;

   assign digit = (req_char_in >= httpdate_pkg::CHAR_ZERO) &&
                  (req_char_in <= httpdate_pkg::CHAR_NINE);
   assign separator = (req_char_in == httpdate_pkg::CHAR_SPACE) ||
                      (req_char_in == httpdate_pkg::CHAR_COLON);
   assign lower = ((req_char_in >= httpdate_pkg::CHAR_UPPER_A) &&
                   (req_char_in <= httpdate_pkg::CHAR_UPPER_Z)) ?
                  (req_char_in | httpdate_pkg::CASE_BIT) : req_char_in;

   // Multiply by ten as two shifts and an add, add the new digit, then saturate.
   assign times_ten = ({4'b0, state_ff.acc} << 3) + ({4'b0, state_ff.acc} << 1) +
                      (NW+4)'(req_char_in[3:0]);
   assign acc_sat = (|times_ten[NW+3:NW]) ? {NW{1'b1}} : times_ten[NW-1:0];

   assign shifted_name = {state_ff.name[15:0], lower};
   assign month_hit = httpdate_pkg::month_number(shifted_name);

   always_comb begin
      parsed = state_ff;
      handled = 1'b0;
      active = !state_ff.err && (state_ff.tok != TOK_DONE);
      if (active) begin
         if (is_number(state_ff.tok) && state_ff.dig) begin
            if (digit) begin
               parsed.acc = acc_sat;
               handled = 1'b1;
            end else begin
               parsed = commit_number(parsed);
               handled = parsed.err;
            end
         end
         if (!handled) begin
            if ((parsed.pos == 2'd0) && separator) begin
               // Separators between tokens are skipped.
            end else if (is_number(parsed.tok)) begin
               if (!digit) begin
                  parsed.err = 1'b1;
               end else begin
                  parsed.acc = NW'(req_char_in[3:0]);
                  parsed.dig = 1'b1;
               end
            end else if ((parsed.tok == TOK_WEEKDAY) && (parsed.pos == 2'd3)) begin
               if (req_char_in != httpdate_pkg::CHAR_COMMA) begin
                  parsed.err = 1'b1;
               end else begin
                  parsed.tok = TOK_DAY;
                  parsed.pos = 2'd0;
                  parsed.name = '0;
               end
            end else begin
               parsed.name = shifted_name;
               parsed.pos = parsed.pos + 2'd1;
               if (parsed.pos == 2'd3) begin
                  if (parsed.tok == TOK_WEEKDAY) begin
                     if (!httpdate_pkg::weekday_match(shifted_name)) parsed.err = 1'b1;
                  end else if (parsed.tok == TOK_MONTH) begin
                     if (month_hit != 4'd0) begin
                        parsed.month = month_hit;
                        parsed.tok = TOK_YEAR;
                        parsed.pos = 2'd0;
                        parsed.name = '0;
                     end else begin
                        parsed.err = 1'b1;
                     end
                  end else begin
                     if (shifted_name == httpdate_pkg::ZONE_GMT) begin
                        parsed.zone = 1'b1;
                        parsed.tok = TOK_DONE;
                     end else begin
                        parsed.err = 1'b1;
                     end
                  end
               end
            end
         end
      end
      // A number still running on the final byte is committed before the result.
      if (req_end_of_text && !parsed.err && (parsed.tok != TOK_DONE) &&
          is_number(parsed.tok) && parsed.dig) begin
         parsed = commit_number(parsed);
      end
   end

   always_comb begin
      state_in = state_ff;
      if (req_fire) begin
         state_in = req_end_of_text ? PARSE_RESET : parsed;
      end
      rsp_valid_in = (req_fire && req_end_of_text) || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PARSE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The result register holds a finished transaction until rsp_ready.
   always_ff @(posedge clock) begin
      if (req_fire && req_end_of_text) begin
         res_ok_ff     <= parsed.zone && !parsed.err;
         res_day_ff    <= 16'(parsed.day);
         res_month_ff  <= parsed.month;
         res_year_ff   <= 16'(parsed.year);
         res_hour_ff   <= 16'(parsed.hour);
         res_minute_ff <= 16'(parsed.minute);
         res_second_ff <= 16'(parsed.second);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = res_ok_ff;
   assign rsp_day_out    = res_day_ff;
   assign rsp_month_out  = res_month_ff;
   assign rsp_year_out   = res_year_ff;
   assign rsp_hour_out   = res_hour_ff;
   assign rsp_minute_out = res_minute_ff;
   assign rsp_second_out = res_second_ff;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for http_date_parser_top: sends date strings byte by byte and
// compares each parse result with a cycle-free predictor kept in this file.
// Depends on httpdate_pkg and rtl/http_date_parser_top.sv.
module tb;

   localparam int HALF_PERIOD    = 5;
   localparam int NUM_W          = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_BYTES   = 880;
   localparam int QUIET_BYTES    = 450;

   // Token positions within a date string.
   localparam logic [3:0] TOK_WEEKDAY = 4'd0;
   localparam logic [3:0] TOK_DAY     = 4'd1;
   localparam logic [3:0] TOK_MONTH   = 4'd2;
   localparam logic [3:0] TOK_YEAR    = 4'd3;
   localparam logic [3:0] TOK_HOUR    = 4'd4;
   localparam logic [3:0] TOK_MINUTE  = 4'd5;
   localparam logic [3:0] TOK_SECOND  = 4'd6;
   localparam logic [3:0] TOK_ZONE    = 4'd7;
   localparam logic [3:0] TOK_DONE    = 4'd8;

   typedef struct packed {
      logic        ok;
      logic [15:0] day;
      logic [3:0]  month;
      logic [15:0] year;
      logic [15:0] hour;
      logic [15:0] minute;
      logic [15:0] sec;
   } date_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_in = 8'd0;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_ok;
   logic [15:0] rsp_day_out;
   logic [3:0]  rsp_month_out;
   logic [15:0] rsp_year_out;
   logic [15:0] rsp_hour_out;
   logic [15:0] rsp_minute_out;
   logic [15:0] rsp_second_out;

   http_date_parser_top #(.NUMBER_WIDTH(NUM_W)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_in     (req_char_in),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ok          (rsp_ok),
      .rsp_day_out     (rsp_day_out),
      .rsp_month_out   (rsp_month_out),
      .rsp_year_out    (rsp_year_out),
      .rsp_hour_out    (rsp_hour_out),
      .rsp_minute_out  (rsp_minute_out),
      .rsp_second_out  (rsp_second_out)
   );

   always #HALF_PERIOD clock = ~clock;

   // Predictor state for the string currently being parsed.
   logic [3:0]     tok_idx;
   logic [2:0]     name_pos;
   logic [23:0]    name_buf;
   logic [NUM_W-1:0] num_acc;
   logic           in_number;
   logic [NUM_W-1:0] day_q, year_q, hour_q, minute_q, second_q;
   logic [3:0]     month_q;
   logic           parse_err;
   logic           gmt_seen;

   date_type    pending_dates[$];
   logic [7:0]  line_buf[$];
   int unsigned errors = 0;
   int unsigned bytes_sent = 0;
   int unsigned lines_sent = 0;
   int unsigned dates_checked = 0;
   int unsigned dates_ok = 0;
   int unsigned quiet_cycles = 0;
   int unsigned gap_pct = 14;
   int unsigned stall_pct = 14;

   function automatic logic known_weekday(input logic [23:0] name);
      case (name)
         "sun", "mon", "tue", "wed", "thu", "fri", "sat": return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [3:0] month_of(input logic [23:0] name);
      case (name)
         "jan": return 4'd1;
         "feb": return 4'd2;
         "mar": return 4'd3;
         "apr": return 4'd4;
         "may": return 4'd5;
         "jun": return 4'd6;
         "jul": return 4'd7;
         "aug": return 4'd8;
         "sep": return 4'd9;
         "oct": return 4'd10;
         "nov": return 4'd11;
         "dec": return 4'd12;
         default: return 4'd0;
      endcase
   endfunction

   function automatic logic numeric_token(input logic [3:0] t);
      return t == TOK_DAY || (t >= TOK_YEAR && t <= TOK_SECOND);
   endfunction

   task automatic clear_parse();
      tok_idx = TOK_WEEKDAY;
      name_pos = '0;
      name_buf = '0;
      num_acc = '0;
      in_number = 1'b0;
      day_q = '0;
      month_q = '0;
      year_q = '0;
      hour_q = '0;
      minute_q = '0;
      second_q = '0;
      parse_err = 1'b0;
      gmt_seen = 1'b0;
   endtask

   task automatic store_number();
      case (tok_idx)
         TOK_DAY:    day_q = num_acc;
         TOK_YEAR: begin
            // A short year is an error and leaves the parse stuck on the year.
            if (num_acc < httpdate_pkg::MIN_YEAR) begin
               parse_err = 1'b1;
               return;
            end
            year_q = num_acc;
         end
         TOK_HOUR:   hour_q = num_acc;
         TOK_MINUTE: minute_q = num_acc;
         TOK_SECOND: second_q = num_acc;
         default: ;
      endcase
      tok_idx++;
      num_acc = '0;
      in_number = 1'b0;
   endtask

   task automatic close_name();
      logic [3:0] mon;
      if (tok_idx == TOK_WEEKDAY) begin
         if (!known_weekday(name_buf)) parse_err = 1'b1;
      end else if (tok_idx == TOK_MONTH) begin
         mon = month_of(name_buf);
         if (mon == 4'd0) begin
            parse_err = 1'b1;
         end else begin
            month_q = mon;
            tok_idx = TOK_YEAR;
            name_pos = '0;
            name_buf = '0;
         end
      end else if (name_buf == httpdate_pkg::ZONE_GMT) begin
         gmt_seen = 1'b1;
         tok_idx = TOK_DONE;
      end else begin
         parse_err = 1'b1;
      end
   endtask

   task automatic parse_char(input logic [7:0] ch);
      logic        is_digit;
      logic [31:0] grown;
      logic [7:0]  lower;
      is_digit = ch >= httpdate_pkg::CHAR_ZERO && ch <= httpdate_pkg::CHAR_NINE;
      if (parse_err || tok_idx >= TOK_DONE) return;
      if (numeric_token(tok_idx) && in_number) begin
         if (is_digit) begin
            grown = 32'(num_acc) * 32'd10 + 32'(ch - httpdate_pkg::CHAR_ZERO);
            num_acc = (grown > 32'((1 << NUM_W) - 1)) ? '1 : grown[NUM_W-1:0];
            return;
         end
         // The byte that ends a number is parsed again as the start of the next token.
         store_number();
         if (parse_err) return;
      end
      if (name_pos == 0 &&
          (ch == httpdate_pkg::CHAR_SPACE || ch == httpdate_pkg::CHAR_COLON)) return;
      if (numeric_token(tok_idx)) begin
         if (!is_digit) begin
            parse_err = 1'b1;
            return;
         end
         num_acc = NUM_W'(ch - httpdate_pkg::CHAR_ZERO);
         in_number = 1'b1;
         return;
      end
      if (tok_idx == TOK_WEEKDAY && name_pos == 3) begin
         if (ch != httpdate_pkg::CHAR_COMMA) begin
            parse_err = 1'b1;
            return;
         end
         tok_idx = TOK_DAY;
         name_pos = '0;
         name_buf = '0;
         return;
      end
      lower = (ch >= httpdate_pkg::CHAR_UPPER_A && ch <= httpdate_pkg::CHAR_UPPER_Z) ?
              (ch | httpdate_pkg::CASE_BIT) : ch;
      name_buf = {name_buf[15:0], lower};
      name_pos++;
      if (name_pos == 3) close_name();
   endtask

   task automatic track_byte(input logic [7:0] ch, input logic last);
      date_type want;
      parse_char(ch);
      if (last) begin
         if (!parse_err && tok_idx < TOK_DONE && numeric_token(tok_idx) && in_number)
            store_number();
         want.ok = gmt_seen && !parse_err;
         want.day = day_q[15:0];
         want.month = month_q;
         want.year = year_q[15:0];
         want.hour = hour_q[15:0];
         want.minute = minute_q[15:0];
         want.sec = second_q[15:0];
         pending_dates.push_back(want);
         clear_parse();
      end
   endtask

   // Each byte goes out as one transaction; valid is left high after acceptance
   // so that back-to-back bytes never lower and raise it in one time step.
   task automatic send_byte(input logic [7:0] ch, input logic last);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_in <= ch;
      req_end_of_text <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      track_byte(ch, last);
      bytes_sent++;
   endtask

   task automatic send_line();
      for (int i = 0; i < line_buf.size(); i++)
         send_byte(line_buf[i], i == line_buf.size() - 1);
      line_buf.delete();
      lines_sent++;
   endtask

   task automatic add_byte(input logic [7:0] b);
      line_buf.push_back(b);
   endtask

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endtask

   task automatic add_seps(input int n);
      repeat (n)
         add_byte($urandom_range(1) ? httpdate_pkg::CHAR_SPACE : httpdate_pkg::CHAR_COLON);
   endtask

   task automatic add_name(input string s);
      logic [7:0] ch;
      for (int i = 0; i < s.len(); i++) begin
         ch = s[i];
         if ($urandom_range(1)) ch = ch & ~httpdate_pkg::CASE_BIT;
         line_buf.push_back(ch);
      end
   endtask

   task automatic add_num(input int unsigned v);
      if ($urandom_range(3) == 0) add_str("0");
      add_str($sformatf("%0d", v));
   endtask

   function automatic string weekday_text(input int k);
      case (k)
         0: return "sun";
         1: return "mon";
         2: return "tue";
         3: return "wed";
         4: return "thu";
         5: return "fri";
         default: return "sat";
      endcase
   endfunction

   function automatic string month_text(input int k);
      case (k)
         0: return "jan";
         1: return "feb";
         2: return "mar";
         3: return "apr";
         4: return "may";
         5: return "jun";
         6: return "jul";
         7: return "aug";
         8: return "sep";
         9: return "oct";
         10: return "nov";
         default: return "dec";
      endcase
   endfunction

   function automatic int unsigned pick_field(input int unsigned lo, input int unsigned hi);
      case ($urandom_range(9))
         0: return $urandom_range(0, 99999);
         1: return $urandom;
         default: return $urandom_range(lo, hi);
      endcase
   endfunction

   function automatic int unsigned pick_year();
      case ($urandom_range(9))
         0, 1: return $urandom_range(0, 998);
         2: return $urandom;
         3: return httpdate_pkg::MIN_YEAR;
         default: return $urandom_range(1000, 9999);
      endcase
   endfunction

   // A date string with random names, letter case, values and separators; the year may be below MIN_YEAR.
   task automatic build_date();
      add_seps($urandom_range(0, 1));
      add_name(weekday_text($urandom_range(0, 6)));
      add_byte(httpdate_pkg::CHAR_COMMA);
      add_seps($urandom_range(0, 2));
      add_num(pick_field(1, 31));
      add_seps($urandom_range(0, 2));
      add_name(month_text($urandom_range(0, 11)));
      add_seps($urandom_range(0, 2));
      add_num(pick_year());
      add_seps($urandom_range(1, 2));
      add_num(pick_field(0, 23));
      add_seps($urandom_range(1, 2));
      add_num(pick_field(0, 59));
      add_seps($urandom_range(1, 2));
      add_num(pick_field(0, 59));
      add_seps($urandom_range(0, 2));
      add_name("gmt");
   endtask

   task automatic send_text(input string s);
      add_str(s);
      send_line();
   endtask

   task automatic test_well_formed();
      send_text("Mon, 26 Apr 2010 14:52:59 GMT");
      send_text("sUN, 01 jAN 1970 00:00:00 gmt");
      send_text("Sat, 31 Dec 9999 23:59:59 GMT");
      send_text("  Wed,:7:feb:0999::1:2:3: GMT");
      send_text("Thu,5Mar2000 1 2 3GMT");
   endtask

   task automatic test_number_overflow();
      send_text("Fri, 4294967296 May 65536 99999 65535 123456789 GMT");
   endtask

   task automatic test_signs();
      send_text("Tue, -5 Jun 2001 10:00:00 GMT");
      send_text("Tue, 5 Jun +2001 10:00:00 GMT");
   endtask

   task automatic test_small_year();
      send_text("Sun, 1 Jul 998 10:00:00 GMT");
      send_text("Sun, 1 Jul 0 10:00:00 GMT");
   endtask

   task automatic test_mismatch();
      send_text("Mox, 26 Apr 2010 14:52:59 GMT");
      send_text("Mon 26 Apr 2010 14:52:59 GMT");
      send_text("Mon, 26 Abr 2010 14:52:59 GMT");
      send_text("Mon, 26 Apr 2010 14:52:59 UTC");
      send_text("Mo n, 26 Apr 2010 14:52:59 GMT");
      send_text("Mon, 26 A:pr 2010 14:52:59 GMT");
   endtask

   task automatic test_after_zone();
      add_str("Mon, 26 Apr 2010 14:52:59 GMT+0100");
      add_byte(8'hFF);
      add_byte(8'h00);
      send_line();
   endtask

   task automatic test_early_end();
      send_text("Mon, 26 Apr 2010");
      send_text("Mon, 26 Apr 998");
      send_text("Mon, 26 Ap");
      send_text("Mon, 26 Apr 2010 14:52:59");
      add_byte(8'hFF);
      send_line();
      add_byte(8'h00);
      send_line();
   endtask

   task automatic test_random_dates();
      int unsigned start;
      int          kind;
      int          pos;
      int          cut;
      start = bytes_sent;
      // The opening stretch runs with both sides always ready.
      gap_pct = 0;
      stall_pct = 0;
      while (bytes_sent - start < RANDOM_BYTES) begin
         if (bytes_sent - start >= QUIET_BYTES) begin
            gap_pct = 14;
            stall_pct = 14;
         end
         kind = $urandom_range(99);
         if (kind < 85) begin
            build_date();
            if (kind >= 70) begin
               if ($urandom_range(1)) begin
                  pos = $urandom_range(0, line_buf.size() - 1);
                  line_buf[pos] = 8'($urandom_range(0, 255));
               end else begin
                  cut = $urandom_range(1, line_buf.size());
                  while (line_buf.size() > cut) void'(line_buf.pop_back());
               end
            end else if ($urandom_range(4) == 0) begin
               repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
            end
         end else begin
            repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
         end
         send_line();
      end
   endtask

   task automatic check_date();
      date_type want;
      if (pending_dates.size() == 0) begin
         $error("result transaction arrived with no date pending");
         errors++;
         return;
      end
      want = pending_dates.pop_front();
      dates_checked++;
      if (want.ok) dates_ok++;
      if (rsp_ok !== want.ok) begin
         $error("rsp_ok: expected %0d, got %0d", want.ok, rsp_ok);
         errors++;
      end
      if (rsp_day_out !== want.day) begin
         $error("rsp_day_out: expected %0d, got %0d", want.day, rsp_day_out);
         errors++;
      end
      if (rsp_month_out !== want.month) begin
         $error("rsp_month_out: expected %0d, got %0d", want.month, rsp_month_out);
         errors++;
      end
      if (rsp_year_out !== want.year) begin
         $error("rsp_year_out: expected %0d, got %0d", want.year, rsp_year_out);
         errors++;
      end
      if (rsp_hour_out !== want.hour) begin
         $error("rsp_hour_out: expected %0d, got %0d", want.hour, rsp_hour_out);
         errors++;
      end
      if (rsp_minute_out !== want.minute) begin
         $error("rsp_minute_out: expected %0d, got %0d", want.minute, rsp_minute_out);
         errors++;
      end
      if (rsp_second_out !== want.sec) begin
         $error("rsp_second_out: expected %0d, got %0d", want.sec, rsp_second_out);
         errors++;
      end
   endtask

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) check_date();
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
               $display("DONE: errors detected");
               $finish;
            end
         end
      end
   end

   initial begin
      clear_parse();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_well_formed();
      test_number_overflow();
      test_signs();
      test_small_year();
      test_mismatch();
      test_after_zone();
      test_early_end();
      test_random_dates();
      req_valid <= 1'b0;
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Sent %0d date strings in %0d bytes; %0d results checked, %0d of them valid.",
               lines_sent, bytes_sent, dates_checked, dates_ok);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
